>>> rtl/core/size_class_pool_allocator_defines.svh
// Assertion macros used by the allocator's port-level checker.
`ifndef SIZE_CLASS_POOL_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

>>> rtl/core/scpa_pkg.sv
// Shared constants, codes and types of the size-class pool allocator.
package scpa_pkg;

    localparam int POOL_DEPTH = 8192;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    localparam int SIZE_W  = 8;
    localparam int INDEX_W = 16;
    localparam int SLOT_W  = 13;
    localparam int CLASS_W = 2;
    localparam int NUM_POOLS = 3;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SMALL_MAX  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEDIUM_MAX = 8'd1;

    localparam logic [SIZE_W-1:0] SMALL_MAX_RESET  = 8'd16;
    localparam logic [SIZE_W-1:0] MEDIUM_MAX_RESET = 8'd32;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [CLASS_W-1:0] CLS_ZERO   = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_SMALL  = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_MEDIUM = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_RANGE     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        logic              pop;
        logic              push;
        logic [ADDR_W-1:0] data;
    } pool_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } pool_stat_t;

endpackage

>>> rtl/core/scpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module scpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/scpa_pool.sv
// One free-index stack: count, low-water mark and stack memory.
module scpa_pool (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  scpa_pkg::pool_cmd_t           cmd,
    output scpa_pkg::pool_stat_t          stat,
    output logic [scpa_pkg::ADDR_W-1:0]   slot
);

    logic [scpa_pkg::CNT_W-1:0]  cnt_reg;
    logic [scpa_pkg::CNT_W-1:0]  cnt_next;
    logic [scpa_pkg::CNT_W-1:0]  low_reg;
    logic [scpa_pkg::CNT_W-1:0]  low_next;
    logic [scpa_pkg::CNT_W-1:0]  cnt_dec;
    logic                        bypass_reg;
    logic                        bypass_next;
    logic [scpa_pkg::ADDR_W-1:0] bypass_val_reg;
    logic [scpa_pkg::ADDR_W-1:0] rd_data;
    logic                        mem_re;

    // Stack positions below the low-water mark were never written since reset,
    // so they still hold their own position as the free index.
    assign cnt_dec     = cnt_reg - scpa_pkg::CNT_W'(1);
    assign stat.empty  = (cnt_reg == '0);
    assign stat.full   = (cnt_reg >= scpa_pkg::CNT_W'(scpa_pkg::POOL_DEPTH));
    assign mem_re      = cmd.pop && (cnt_reg != low_reg);

    always_comb begin
        cnt_next    = cnt_reg;
        low_next    = low_reg;
        bypass_next = bypass_reg;
        if (cmd.pop) begin
            cnt_next    = cnt_dec;
            bypass_next = (cnt_reg == low_reg);
            if (cnt_reg == low_reg) begin
                low_next = cnt_dec;
            end
        end else if (cmd.push) begin
            cnt_next = cnt_reg + scpa_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= scpa_pkg::CNT_W'(scpa_pkg::POOL_DEPTH);
            low_reg    <= scpa_pkg::CNT_W'(scpa_pkg::POOL_DEPTH);
            bypass_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            low_reg    <= low_next;
            bypass_reg <= bypass_next;
        end
        if (cmd.pop) begin
            bypass_val_reg <= cnt_dec[scpa_pkg::ADDR_W-1:0];
        end
    end

    scpa_ram #(
        .WIDTH (scpa_pkg::ADDR_W),
        .DEPTH (scpa_pkg::POOL_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (cnt_reg[scpa_pkg::ADDR_W-1:0]),
        .wdata (cmd.data),
        .re    (mem_re),
        .raddr (cnt_dec[scpa_pkg::ADDR_W-1:0]),
        .rdata (rd_data)
    );

    assign slot = bypass_reg ? bypass_val_reg : rd_data;

endmodule

>>> rtl/core/size_class_pool_allocator.sv
// Top level of the size-class pool allocator: class selection, pools, result stage.
//
//   Channel  Direction  Handshake             Payload
//   s_       in         s_tvalid / s_tready   request: type, size, slot index
//   m_       out        m_tvalid / m_tready   result: slot, class, status
//   cfg_     in         cfg_valid / cfg_ready register index and data
//
// One request per cycle while the result side is not stalled; its result appears in the
// cycle after acceptance, set by the registered read of the selected pool's stack memory.
// Free counts live in flip-flops, so consecutive requests to one pool need no stall.
// A low-water mark per pool stands in for the initial stack contents, so no clearing
// pass is needed at reset.
// A stalled result holds the input side, since the result stage is one deep.
module size_class_pool_allocator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] size_bytes, [23:8] slot_index
    input  logic [scpa_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] req_type
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [12:0] granted_slot, [14:13] size_class, [15] zero
    output logic [scpa_pkg::M_TDATA_W-1:0]      m_tdata,
    // [2:0] status
    output logic [scpa_pkg::M_TUSER_W-1:0]      m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [scpa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [scpa_pkg::SIZE_W-1:0]   small_max_reg;
    logic [scpa_pkg::SIZE_W-1:0]   medium_max_reg;
    logic [scpa_pkg::SIZE_W-1:0]   size_bytes;
    logic [scpa_pkg::INDEX_W-1:0]  slot_index;
    logic                          accept;
    logic                          too_large;
    logic                          out_of_range;
    logic [scpa_pkg::CLASS_W-1:0]  cls_sel;
    logic [scpa_pkg::CLASS_W-1:0]  cls_next;
    scpa_pkg::status_t             status_next;
    logic                          grant_next;
    logic                          sel_empty;
    logic                          sel_full;
    logic                          do_pop;
    logic                          do_push;

    logic                          out_valid_reg;
    logic [scpa_pkg::CLASS_W-1:0]  cls_reg;
    scpa_pkg::status_t             status_reg;
    logic                          grant_reg;
    logic [scpa_pkg::ADDR_W-1:0]   sel_slot;
    logic [scpa_pkg::SLOT_W-1:0]   granted_slot;

    scpa_pkg::pool_cmd_t           pool_cmd  [scpa_pkg::NUM_POOLS];
    scpa_pkg::pool_stat_t          pool_stat [scpa_pkg::NUM_POOLS];
    logic [scpa_pkg::ADDR_W-1:0]   pool_slot [scpa_pkg::NUM_POOLS];

    assign size_bytes = s_tdata[scpa_pkg::SIZE_W-1:0];
    assign slot_index = s_tdata[scpa_pkg::SIZE_W +: scpa_pkg::INDEX_W];
    assign cfg_ready  = aresetn;
    assign s_tready   = aresetn && (!out_valid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            small_max_reg  <= scpa_pkg::SMALL_MAX_RESET;
            medium_max_reg <= scpa_pkg::MEDIUM_MAX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                scpa_pkg::CFG_SMALL_MAX:  small_max_reg  <= cfg_data;
                scpa_pkg::CFG_MEDIUM_MAX: medium_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        too_large = 1'b0;
        if (size_bytes == '0) begin
            cls_sel = scpa_pkg::CLS_ZERO;
        end else if (size_bytes <= small_max_reg) begin
            cls_sel = scpa_pkg::CLS_SMALL;
        end else if (size_bytes <= medium_max_reg) begin
            cls_sel = scpa_pkg::CLS_MEDIUM;
        end else begin
            cls_sel   = scpa_pkg::CLS_ZERO;
            too_large = 1'b1;
        end
    end

    always_comb begin
        case (cls_sel)
            scpa_pkg::CLS_SMALL: begin
                sel_empty = pool_stat[1].empty;
                sel_full  = pool_stat[1].full;
            end
            scpa_pkg::CLS_MEDIUM: begin
                sel_empty = pool_stat[2].empty;
                sel_full  = pool_stat[2].full;
            end
            default: begin
                sel_empty = pool_stat[0].empty;
                sel_full  = pool_stat[0].full;
            end
        endcase
    end

    assign out_of_range = {1'b0, slot_index} >=
                          (scpa_pkg::INDEX_W + 1)'(scpa_pkg::POOL_DEPTH);

    always_comb begin
        cls_next    = cls_sel;
        grant_next  = 1'b0;
        status_next = scpa_pkg::ST_OK;
        if (too_large) begin
            status_next = scpa_pkg::ST_TOO_LARGE;
        end else if (s_tuser == scpa_pkg::REQ_ALLOC) begin
            if (sel_empty) begin
                status_next = scpa_pkg::ST_EMPTY;
            end else begin
                grant_next = 1'b1;
            end
        end else if (out_of_range) begin
            status_next = scpa_pkg::ST_RANGE;
        end else if (sel_full) begin
            status_next = scpa_pkg::ST_FULL;
        end
    end

    assign do_pop  = accept && grant_next;
    assign do_push = accept && !too_large && (s_tuser == scpa_pkg::REQ_FREE) &&
                     (status_next == scpa_pkg::ST_OK);

    for (genvar p = 0; p < scpa_pkg::NUM_POOLS; p++) begin : g_pool
        assign pool_cmd[p].pop  = do_pop && (cls_sel == scpa_pkg::CLASS_W'(p));
        assign pool_cmd[p].push = do_push && (cls_sel == scpa_pkg::CLASS_W'(p));
        assign pool_cmd[p].data = slot_index[scpa_pkg::ADDR_W-1:0];

        scpa_pool u_pool (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (pool_cmd[p]),
            .stat    (pool_stat[p]),
            .slot    (pool_slot[p])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (accept) begin
            cls_reg    <= cls_next;
            status_reg <= status_next;
            grant_reg  <= grant_next;
        end
    end

    always_comb begin
        case (cls_reg)
            scpa_pkg::CLS_SMALL:  sel_slot = pool_slot[1];
            scpa_pkg::CLS_MEDIUM: sel_slot = pool_slot[2];
            default:              sel_slot = pool_slot[0];
        endcase
    end

    assign granted_slot = grant_reg ? scpa_pkg::SLOT_W'(sel_slot) : '0;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {1'b0, cls_reg, granted_slot};
    assign m_tuser      = status_reg;

endmodule

>>> rtl/core/scpa_checker.sv
// Port-level checker for the size-class pool allocator, with its bind.
`include "size_class_pool_allocator_defines.svh"

module scpa_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [scpa_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic [scpa_pkg::M_TUSER_W-1:0]      m_tuser
);

    `SCPA_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `SCPA_ASSERT_NEXT(a_one_cycle_latency, aclk, aresetn, s_tvalid && s_tready, m_tvalid)
    `SCPA_ASSERT_IMP(a_slot_only_on_ok, aclk, aresetn,
        m_tvalid && (m_tuser != 3'(scpa_pkg::ST_OK)), m_tdata[12:0] == '0)
    `SCPA_ASSERT_IMP(a_too_large_class, aclk, aresetn,
        m_tvalid && (m_tuser == 3'(scpa_pkg::ST_TOO_LARGE)),
        m_tdata[14:13] == scpa_pkg::CLS_ZERO)

endmodule

bind size_class_pool_allocator scpa_checker u_scpa_checker (.*);

>>> dv/size_class_pool_allocator_check.sv
// Checker that predicts and compares every result of the size-class pool allocator.
`timescale 1ns / 1ps

module size_class_pool_allocator_check
    import scpa_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic [M_TUSER_W-1:0]   m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     waiting,
    output int                     failures
);

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [CLASS_W-1:0] cls;
        status_t            status;
    } grant_t;

    logic [SLOT_W-1:0] free_slots [NUM_POOLS][POOL_DEPTH];
    int                free_cnt [NUM_POOLS];
    logic [SIZE_W-1:0] small_max;
    logic [SIZE_W-1:0] medium_max;
    grant_t            grants_q [$];

    function automatic grant_t serve_request(logic req, logic [SIZE_W-1:0] size,
                                             logic [INDEX_W-1:0] idx);
        grant_t g;
        int     pool;
        g.slot   = '0;
        g.cls    = CLS_ZERO;
        g.status = ST_OK;
        if (size == '0) begin
            g.cls = CLS_ZERO;
        end else if (size <= small_max) begin
            g.cls = CLS_SMALL;
        end else if (size <= medium_max) begin
            g.cls = CLS_MEDIUM;
        end else begin
            g.status = ST_TOO_LARGE;
            return g;
        end
        pool = int'(g.cls);
        if (req == REQ_ALLOC) begin
            if (free_cnt[pool] == 0) begin
                g.status = ST_EMPTY;
            end else begin
                free_cnt[pool]--;
                g.slot = free_slots[pool][free_cnt[pool]];
            end
        end else if (idx >= POOL_DEPTH) begin
            g.status = ST_RANGE;
        end else if (free_cnt[pool] >= POOL_DEPTH) begin
            g.status = ST_FULL;
        end else begin
            free_slots[pool][free_cnt[pool]] = idx[SLOT_W-1:0];
            free_cnt[pool]++;
        end
        return g;
    endfunction

    function automatic void check_field(string field, logic [15:0] want_v,
                                        logic [15:0] got_v);
        if (got_v !== want_v) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
        end
    endfunction

    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            for (int p = 0; p < NUM_POOLS; p++) begin
                for (int i = 0; i < POOL_DEPTH; i++) begin
                    free_slots[p][i] = SLOT_W'(i);
                end
                free_cnt[p] = POOL_DEPTH;
            end
            small_max  = SMALL_MAX_RESET;
            medium_max = MEDIUM_MAX_RESET;
            failures   = 0;
            grants_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (grants_q.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = grants_q.pop_front();
                    check_field("granted_slot", 16'(want.slot), 16'(m_tdata[SLOT_W-1:0]));
                    check_field("size_class", 16'(want.cls), 16'(m_tdata[SLOT_W +: CLASS_W]));
                    check_field("status", 16'(want.status), 16'(m_tuser));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SMALL_MAX) begin
                    small_max = cfg_data;
                end else if (cfg_index == CFG_MEDIUM_MAX) begin
                    medium_max = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                grants_q.push_back(serve_request(s_tuser, s_tdata[SIZE_W-1:0],
                                                 s_tdata[SIZE_W +: INDEX_W]));
            end
        end
        waiting <= grants_q.size();
    end

endmodule

>>> dv/size_class_pool_allocator_test.sv
// Testbench top of the size-class pool allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module size_class_pool_allocator_test;

    import scpa_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_STALL  = 400;
    localparam int CHUNK_ITEMS = 210;
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = CFG_MEDIUM_MAX + 8'd1;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int waiting;
    int failures;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int quiet_cycles = 0;
    bit stall_long   = 1'b0;

    logic [SIZE_W-1:0] cur_small  = SMALL_MAX_RESET;
    logic [SIZE_W-1:0] cur_medium = MEDIUM_MAX_RESET;

    logic [SIZE_W-1:0] small_set  [9] = '{8'd1, 8'd255, 8'd100, 8'd0, 8'd40,
                                          8'd255, 8'd1, 8'd8, 8'd16};
    logic [SIZE_W-1:0] medium_set [9] = '{8'd255, 8'd255, 8'd50, 8'd1, 8'd200,
                                          8'd1, 8'd2, 8'd8, 8'd32};

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    size_class_pool_allocator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    size_class_pool_allocator_check alloc_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .waiting   (waiting),
        .failures  (failures)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("size_class_pool_allocator_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The receiver holds off for a long stretch whenever the stimulus asks for it.
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_long) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                stall_long = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_request(logic req, logic [SIZE_W-1:0] size, logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {idx, size};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (waiting != 0);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic cfg_write(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (index == CFG_SMALL_MAX) begin
            cur_small = data;
        end else if (index == CFG_MEDIUM_MAX) begin
            cur_medium = data;
        end
    endtask

    task automatic random_request();
        int                 pick;
        logic               req;
        logic [SIZE_W-1:0]  size;
        logic [INDEX_W-1:0] idx;
        pick = $urandom_range(99);
        if (pick < 12) begin
            size = '0;
        end else if (pick < 20) begin
            size = cur_small;
        end else if (pick < 28) begin
            size = cur_small + 8'd1;
        end else if (pick < 36) begin
            size = cur_medium;
        end else if (pick < 44) begin
            size = cur_medium + 8'd1;
        end else if (pick < 50) begin
            size = 8'd255;
        end else begin
            size = SIZE_W'($urandom_range(255));
        end
        req  = ($urandom_range(99) < 55) ? REQ_ALLOC : REQ_FREE;
        pick = $urandom_range(99);
        if (pick < 85) begin
            idx = INDEX_W'($urandom_range(POOL_DEPTH - 1));
        end else if (pick < 90) begin
            idx = pick[0] ? INDEX_W'(POOL_DEPTH - 1) : '0;
        end else begin
            idx = INDEX_W'($urandom_range(65535, POOL_DEPTH));
        end
        send_request(req, size, idx);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 15;
        rx_idle_pct = 66;

        // Directed requests against the reset limits of 16 and 32 bytes.
        send_request(REQ_FREE, 8'd0, 16'd5);
        send_request(REQ_FREE, 8'd16, 16'd0);
        send_request(REQ_FREE, 8'd32, 16'd8191);
        send_request(REQ_FREE, 8'd33, 16'd3);
        send_request(REQ_ALLOC, 8'd255, 16'd0);
        send_request(REQ_ALLOC, 8'd0, 16'd0);
        send_request(REQ_ALLOC, 8'd1, 16'd0);
        send_request(REQ_ALLOC, 8'd16, 16'd0);
        send_request(REQ_ALLOC, 8'd17, 16'd0);
        send_request(REQ_ALLOC, 8'd32, 16'd0);
        send_request(REQ_FREE, 8'd1, 16'd8192);
        send_request(REQ_FREE, 8'd1, 16'hFFFF);
        send_request(REQ_FREE, 8'd5, 16'h1234);
        send_request(REQ_FREE, 8'd5, 16'h1234);
        send_request(REQ_ALLOC, 8'd5, 16'd0);
        send_request(REQ_FREE, 8'd20, 16'd8191);
        send_request(REQ_FREE, 8'd0, 16'd0);
        send_request(REQ_ALLOC, 8'd0, 16'd0);
        send_request(REQ_ALLOC, 8'd20, 16'd0);
        send_request(REQ_FREE, 8'd0, 16'h1FFF);
        send_request(REQ_FREE, 8'd255, 16'hFFFF);
        send_request(REQ_ALLOC, 8'd33, 16'hFFFF);

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 66 : 0;
            rx_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 15 : 0;
            for (int n = 0; n < 3; n++) begin
                wait_drained();
                if (mode == 0 && n == 2) begin
                    cfg_write(CFG_NO_REG, 8'hFF);
                end
                cfg_write(CFG_SMALL_MAX, small_set[mode * 3 + n]);
                cfg_write(CFG_MEDIUM_MAX, medium_set[mode * 3 + n]);
                cfg_valid <= 1'b0;
                if (mode == 2 && n == 0) begin
                    stall_long = 1'b1;
                end
                for (int k = 0; k < CHUNK_ITEMS; k++) begin
                    if ($urandom_range(199) == 0) begin
                        wait_drained();
                    end
                    random_request();
                end
            end
        end

        // A last mix of requests after the pipeline has drained.
        wait_drained();
        for (int k = 0; k < 60; k++) begin
            random_request();
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (failures == 0) begin
            $display("size_class_pool_allocator_test OK");
        end else begin
            $display("size_class_pool_allocator_test NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/scpa_pkg.sv
rtl/core/scpa_ram.sv
rtl/core/scpa_pool.sv
rtl/core/size_class_pool_allocator.sv
rtl/core/scpa_checker.sv
dv/size_class_pool_allocator_check.sv
dv/size_class_pool_allocator_test.sv
